/* design/obb_overlap_test_unit_macros.svh */
// Assertion helpers shared by the overlap test unit.
`ifndef OBB_OVERLAP_TEST_UNIT_MACROS_SVH
`define OBB_OVERLAP_TEST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OBB_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OBB_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* design/obb_pkg.sv */
package obb_pkg;

   // Slot numbering of the vector store.
   localparam int SLOT_W      = 4;
   localparam int NUM_SLOT    = 10;
   localparam logic [SLOT_W-1:0] SLOT_A_CTR  = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_A_HALF = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_B_CTR  = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_B_HALF = 4'd9;

   // Candidate axes: six box axes, then nine cross products.
   localparam logic [3:0] NUM_BOX_AXES = 4'd6;
   localparam logic [3:0] LAST_AXIS    = 4'd14;

   // Component selectors.
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

endpackage

/* design/obb_overlap_test_unit.sv */
// Oriented box overlap test by the separating axis theorem. Ten vectors are loaded one
// beat at a time (centre, three axes and half sizes for box A in slots 0-4, box B in 5-9);
// a beat with req_last set starts the test, and one rsp beat then reports overlap. All
// arithmetic is exact. Every product goes through one shared shift-and-add multiplier that
// retires one multiplier bit a cycle, with a set-up state before it and a write-back state
// after it. A box axis needs 27 products and a cross-product axis 33; the test stops at
// the first separating axis. The block takes no beat while a test runs; while idle it
// takes load beats back to back.
module obb_overlap_test_unit
   import obb_pkg::*;
#(
   parameter int COMP_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SLOT_W-1:0]            req_slot,
   input  logic signed [COMP_WIDTH-1:0] req_comp_x,
   input  logic signed [COMP_WIDTH-1:0] req_comp_y,
   input  logic signed [COMP_WIDTH-1:0] req_comp_z,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_overlap
);

   localparam int MB    = COMP_WIDTH + 1;
   localparam int AW    = 2 * COMP_WIDTH + 2;
   localparam int ACC_W = 4 * COMP_WIDTH + FRAC_BITS + 8;
   localparam int CNT_W = $clog2(MB);

   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic signed [MB-1:0]         mpl_type;
   typedef logic signed [AW-1:0]         axis_type;
   typedef logic signed [COMP_WIDTH-1:0] comp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_AXIS, S_LOADV, S_XMAC, S_XEND, S_DMAC, S_DEND,
      S_PMAC, S_PEND, S_HMAC, S_HEND, S_MUL, S_CMP, S_OUT
   } state_type;

   // Box axis number (0-5) to store slot.
   function automatic logic [SLOT_W-1:0] axis_slot(input logic [2:0] n);
      logic [SLOT_W-1:0] s;
      s = (n < 3'd3) ? SLOT_W'(n) + SLOT_W'(1) : SLOT_W'(n) + SLOT_W'(3);
      return s;
   endfunction

   // Cyclic successor of a component index.
   function automatic logic [1:0] next_comp(input logic [1:0] c);
      logic [1:0] r;
      case (c)
         COMP_X:  r = COMP_Y;
         COMP_Y:  r = COMP_Z;
         default: r = COMP_X;
      endcase
      return r;
   endfunction

   // Cross-product axis (6-14) to the A axis and B axis that form it.
   function automatic logic [3:0] cross_ij(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'd6:    r = {2'd0, 2'd0};
         4'd7:    r = {2'd0, 2'd1};
         4'd8:    r = {2'd0, 2'd2};
         4'd9:    r = {2'd1, 2'd0};
         4'd10:   r = {2'd1, 2'd1};
         4'd11:   r = {2'd1, 2'd2};
         4'd12:   r = {2'd2, 2'd0};
         4'd13:   r = {2'd2, 2'd1};
         default: r = {2'd2, 2'd2};
      endcase
      return r;
   endfunction

   function automatic acc_type abs_acc(input acc_type v);
      acc_type r;
      r = v[ACC_W-1] ? -v : v;
      return r;
   endfunction

   // Vector store.
   comp_type store_x_ff [NUM_SLOT];
   comp_type store_y_ff [NUM_SLOT];
   comp_type store_z_ff [NUM_SLOT];

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [3:0]       axis_ff, axis_in;
   logic [1:0]       comp_ff, comp_in;
   logic             term_ff, term_in;
   logic [2:0]       bk_ff, bk_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   mpl_type          d_ff [3];
   mpl_type          d_in [3];
   axis_type         a_ff [3];
   axis_type         a_in [3];
   comp_type         u_ff [3];
   comp_type         u_in [3];
   comp_type         v_ff [3];
   comp_type         v_in [3];
   acc_type          acc_ff, acc_in, mcand_ff, mcand_in, dot_ff, dot_in;
   acc_type          lhs_ff, lhs_in, rhs_ff, rhs_in;
   mpl_type          mplier_ff, mplier_in;
   logic             result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in, rsp_overlap_ff, rsp_overlap_in;

   logic              req_fire;
   logic [SLOT_W-1:0] rd_slot;
   logic [1:0]        rd_comp;
   comp_type          rd_x, rd_y, rd_z, rd_val;
   logic [3:0]        ij;
   logic [1:0]        ci1, ci2;
   acc_type           addend;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid & req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

   assign ij  = cross_ij(axis_ff);
   assign ci1 = next_comp(comp_ff);
   assign ci2 = next_comp(ci1);

   // Single muxed read port of the store: one slot a cycle; the centre difference reads its two slots directly.
   always_comb begin
      rd_slot = axis_slot(bk_ff);
      rd_comp = comp_ff;
      case (state_ff)
         S_AXIS: begin
            rd_slot = (axis_ff < NUM_BOX_AXES) ? axis_slot(axis_ff[2:0])
                                               : axis_slot({1'b0, ij[3:2]});
         end
         S_LOADV: rd_slot = axis_slot(3'd3 + {1'b0, ij[1:0]});
         S_HMAC: begin
            rd_slot = (bk_ff < 3'd3) ? SLOT_A_HALF : SLOT_B_HALF;
            rd_comp = (bk_ff < 3'd3) ? bk_ff[1:0] : 2'(bk_ff - 3'd3);
         end
         default: rd_slot = axis_slot(bk_ff);
      endcase
   end

   assign rd_x = store_x_ff[rd_slot];
   assign rd_y = store_y_ff[rd_slot];
   assign rd_z = store_z_ff[rd_slot];

   always_comb begin
      case (rd_comp)
         COMP_X:  rd_val = rd_x;
         COMP_Y:  rd_val = rd_y;
         default: rd_val = rd_z;
      endcase
   end

   // Store write on every load beat with a slot in range.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOT; i++) begin
            store_x_ff[i] <= '0;
            store_y_ff[i] <= '0;
            store_z_ff[i] <= '0;
         end
      end else if (req_fire && (req_slot < SLOT_W'(NUM_SLOT))) begin
         store_x_ff[req_slot] <= req_comp_x;
         store_y_ff[req_slot] <= req_comp_y;
         store_z_ff[req_slot] <= req_comp_z;
      end
   end

   // Shared multiplier step: signed multiplier, last bit carries negative weight.
   assign addend = mplier_ff[0] ? ((cnt_ff == CNT_W'(MB - 1)) ? -mcand_ff : mcand_ff)
                                : '0;

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      axis_in        = axis_ff;
      comp_in        = comp_ff;
      term_in        = term_ff;
      bk_in          = bk_ff;
      cnt_in         = cnt_ff;
      d_in           = d_ff;
      a_in           = a_ff;
      u_in           = u_ff;
      v_in           = v_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      dot_in         = dot_ff;
      lhs_in         = lhs_ff;
      rhs_in         = rhs_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_overlap_in = rsp_overlap_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_last) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            // Centre difference, read at the two fixed centre slots.
            d_in[0]  = MB'(store_x_ff[SLOT_B_CTR]) - MB'(store_x_ff[SLOT_A_CTR]);
            d_in[1]  = MB'(store_y_ff[SLOT_B_CTR]) - MB'(store_y_ff[SLOT_A_CTR]);
            d_in[2]  = MB'(store_z_ff[SLOT_B_CTR]) - MB'(store_z_ff[SLOT_A_CTR]);
            axis_in  = '0;
            state_in = S_AXIS;
         end
         S_AXIS: begin
            acc_in  = '0;
            comp_in = COMP_X;
            term_in = 1'b0;
            if (axis_ff < NUM_BOX_AXES) begin
               a_in[0]  = AW'(rd_x);
               a_in[1]  = AW'(rd_y);
               a_in[2]  = AW'(rd_z);
               state_in = S_DMAC;
            end else begin
               u_in[0]  = rd_x;
               u_in[1]  = rd_y;
               u_in[2]  = rd_z;
               state_in = S_LOADV;
            end
         end
         S_LOADV: begin
            v_in[0]  = rd_x;
            v_in[1]  = rd_y;
            v_in[2]  = rd_z;
            state_in = S_XMAC;
         end
         S_XMAC: begin
            // Cross component: u[c+1]*v[c+2] - u[c+2]*v[c+1].
            if (!term_ff) begin
               mcand_in  = ACC_W'(u_ff[ci1]);
               mplier_in = MB'(v_ff[ci2]);
            end else begin
               mcand_in  = -ACC_W'(u_ff[ci2]);
               mplier_in = MB'(v_ff[ci1]);
            end
            cnt_in   = '0;
            ret_in   = S_XEND;
            state_in = S_MUL;
         end
         S_XEND: begin
            if (!term_ff) begin
               term_in  = 1'b1;
               state_in = S_XMAC;
            end else begin
               a_in[comp_ff] = $signed(acc_ff[AW-1:0]);
               acc_in        = '0;
               term_in       = 1'b0;
               if (comp_ff == COMP_Z) begin
                  comp_in  = COMP_X;
                  state_in = S_DMAC;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_XMAC;
               end
            end
         end
         S_DMAC: begin
            mcand_in  = ACC_W'(a_ff[comp_ff]);
            mplier_in = d_ff[comp_ff];
            cnt_in    = '0;
            ret_in    = S_DEND;
            state_in  = S_MUL;
         end
         S_DEND: begin
            if (comp_ff != COMP_Z) begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_DMAC;
            end else begin
               lhs_in   = abs_acc(acc_ff) <<< FRAC_BITS;
               acc_in   = '0;
               rhs_in   = '0;
               bk_in    = '0;
               comp_in  = COMP_X;
               state_in = S_PMAC;
            end
         end
         S_PMAC: begin
            mcand_in  = ACC_W'(a_ff[comp_ff]);
            mplier_in = MB'(rd_val);
            cnt_in    = '0;
            ret_in    = S_PEND;
            state_in  = S_MUL;
         end
         S_PEND: begin
            if (comp_ff != COMP_Z) begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_PMAC;
            end else begin
               dot_in   = acc_ff;
               acc_in   = '0;
               comp_in  = COMP_X;
               state_in = S_HMAC;
            end
         end
         S_HMAC: begin
            mcand_in  = dot_ff;
            mplier_in = MB'(rd_val);
            cnt_in    = '0;
            ret_in    = S_HEND;
            state_in  = S_MUL;
         end
         S_HEND: begin
            rhs_in = rhs_ff + abs_acc(acc_ff);
            acc_in = '0;
            if (bk_ff == 3'd5) begin
               state_in = S_CMP;
            end else begin
               bk_in    = bk_ff + 3'd1;
               state_in = S_PMAC;
            end
         end
         S_MUL: begin
            acc_in    = acc_ff + addend;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >>> 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MB - 1)) begin
               state_in = ret_ff;
            end
         end
         S_CMP: begin
            if (lhs_ff > rhs_ff) begin
               result_in = 1'b0;
               state_in  = S_OUT;
            end else if (axis_ff == LAST_AXIS) begin
               result_in = 1'b1;
               state_in  = S_OUT;
            end else begin
               axis_in  = axis_ff + 4'd1;
               state_in = S_AXIS;
            end
         end
         S_OUT: begin
            // Wait for the output register to be free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_overlap_in = result_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff        <= axis_in;
      comp_ff        <= comp_in;
      term_ff        <= term_in;
      bk_ff          <= bk_in;
      cnt_ff         <= cnt_in;
      d_ff           <= d_in;
      a_ff           <= a_in;
      u_ff           <= u_in;
      v_ff           <= v_in;
      acc_ff         <= acc_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      dot_ff         <= dot_in;
      lhs_ff         <= lhs_in;
      rhs_ff         <= rhs_in;
      result_ff      <= result_in;
      rsp_overlap_ff <= rsp_overlap_in;
   end

   // Checks on the sequencer.
   `include "obb_overlap_test_unit_macros.svh"

   `OBB_ASSERT_NEXT(a_start, req_valid && req_ready && req_last, state_ff == S_DIFF, "test did not start")
   `OBB_ASSERT_NOW(a_busy, state_ff != S_IDLE, !req_ready, "beat taken while a test runs")
   `OBB_ASSERT_NOW(a_mul_cnt, state_ff == S_MUL, cnt_ff <= CNT_W'(MB - 1), "multiplier count overrun")
   `OBB_ASSERT_NOW(a_axis, state_ff == S_CMP, axis_ff <= LAST_AXIS, "axis index out of range")

endmodule

/* bench/obb_overlap_test_unit_test.sv */
module obb_overlap_test_unit_test
   import obb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_type;
   typedef logic signed [31:0]  comp_type;

   localparam int FRAC = 16;

   // Keeps a copy of the vector store, works out the overlap verdict of each
   // test beat and checks the returned verdicts in order.
   class overlap_board_type;
      comp_type vec_x [NUM_SLOT];
      comp_type vec_y [NUM_SLOT];
      comp_type vec_z [NUM_SLOT];
      bit       verdicts [$];
      int       failures;

      function new();
         failures = 0;
         foreach (vec_x[i]) begin
            vec_x[i] = '0;
            vec_y[i] = '0;
            vec_z[i] = '0;
         end
      endfunction

      static function wide_type mag(wide_type v);
         return (v < 0) ? -v : v;
      endfunction

      static function wide_type dot(wide_type a [3], wide_type b [3]);
         return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      endfunction

      // An axis separates when the projected centre distance exceeds the sum
      // of all six projected half extents; the distance side is rescaled.
      static function bit separates(wide_type d [3], wide_type a [3],
                                    wide_type ax [2][3][3], wide_type hs [2][3]);
         wide_type lhs;
         wide_type rhs;
         lhs = mag(dot(d, a)) <<< FRAC;
         rhs = '0;
         for (int b = 0; b < 2; b++)
            for (int k = 0; k < 3; k++)
               rhs = rhs + mag(hs[b][k] * dot(ax[b][k], a));
         return lhs > rhs;
      endfunction

      function bit boxes_overlap();
         wide_type d [3];
         wide_type a [3];
         wide_type ax [2][3][3];
         wide_type hs [2][3];
         for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < 3; i++) begin
               ax[b][i][0] = vec_x[b*5+1+i];
               ax[b][i][1] = vec_y[b*5+1+i];
               ax[b][i][2] = vec_z[b*5+1+i];
            end
            hs[b][0] = vec_x[b*5+4];
            hs[b][1] = vec_y[b*5+4];
            hs[b][2] = vec_z[b*5+4];
         end
         d[0] = wide_type'(vec_x[SLOT_B_CTR]) - wide_type'(vec_x[SLOT_A_CTR]);
         d[1] = wide_type'(vec_y[SLOT_B_CTR]) - wide_type'(vec_y[SLOT_A_CTR]);
         d[2] = wide_type'(vec_z[SLOT_B_CTR]) - wide_type'(vec_z[SLOT_A_CTR]);
         for (int b = 0; b < 2; b++)
            for (int i = 0; i < 3; i++)
               if (separates(d, ax[b][i], ax, hs))
                  return 1'b0;
         // Cross products of box A axis i with box B axis j.
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               a[0] = ax[0][i][1] * ax[1][j][2] - ax[0][i][2] * ax[1][j][1];
               a[1] = ax[0][i][2] * ax[1][j][0] - ax[0][i][0] * ax[1][j][2];
               a[2] = ax[0][i][0] * ax[1][j][1] - ax[0][i][1] * ax[1][j][0];
               if (separates(d, a, ax, hs))
                  return 1'b0;
            end
         return 1'b1;
      endfunction

      function void note_beat(logic [SLOT_W-1:0] slot, comp_type x, comp_type y,
                              comp_type z, bit last);
         if (slot < NUM_SLOT) begin
            vec_x[slot] = x;
            vec_y[slot] = y;
            vec_z[slot] = z;
         end
         if (last)
            verdicts.push_back(boxes_overlap());
      endfunction

      function void check_result(bit overlap);
         bit want;
         if (verdicts.size() == 0) begin
            $error("overlap: result %0d arrived with none expected", overlap);
            failures++;
            return;
         end
         want = verdicts.pop_front();
         if (overlap !== want) begin
            $error("overlap: expected %0d, actual %0d", want, overlap);
            failures++;
         end
      endfunction

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [SLOT_W-1:0]   req_slot;
   logic signed [31:0]  req_comp_x;
   logic signed [31:0]  req_comp_y;
   logic signed [31:0]  req_comp_z;
   logic                req_last;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_overlap;

   overlap_board_type board = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int beats_sent     = 0;

   obb_overlap_test_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_slot    (req_slot),
      .req_comp_x  (req_comp_x),
      .req_comp_y  (req_comp_y),
      .req_comp_z  (req_comp_z),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_overlap (rsp_overlap)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Result side: random stalls, and every accepted beat is checked.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_overlap);
   end

   // Drives one request beat, with a random idle gap in front of it.
   task automatic send_beat(logic [SLOT_W-1:0] slot, comp_type x, comp_type y,
                            comp_type z, bit last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_slot   <= slot;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      req_last   <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.note_beat(slot, x, y, z, last);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   function automatic comp_type rand_comp(int kind);
      case (kind)
         0:       return comp_type'($urandom_range(12 << FRAC)) - (6 << FRAC);
         1:       return comp_type'($urandom());
         default: return comp_type'($urandom_range(1 << 19)) - (1 << 18);
      endcase
   endfunction

   // Loads a full box pair in random slot order with noise beats mixed in;
   // the final load carries the last flag.
   task automatic send_box_pair();
      int       kind;
      int       order [10];
      int       rot_a;
      int       rot_b;
      comp_type v [3];
      int       s;
      kind  = $urandom_range(2);
      rot_a = $urandom_range(2);
      rot_b = $urandom_range(2);
      foreach (order[i])
         order[i] = i;
      order.shuffle();
      for (int n = 0; n < 10; n++) begin
         // Occasional noise, sometimes a premature test or an unused slot.
         if ($urandom_range(9) == 0)
            send_beat($urandom_range(15), comp_type'($urandom()), comp_type'($urandom()),
                      comp_type'($urandom()), $urandom_range(7) == 0);
         s = order[n];
         for (int c = 0; c < 3; c++)
            v[c] = rand_comp(kind);
         if (kind == 0 && s % 5 >= 1 && s % 5 <= 3) begin
            // Signed unit axes, permuted, so many pairs overlap.
            for (int c = 0; c < 3; c++)
               v[c] = '0;
            v[(s % 5 - 1 + (s < 5 ? rot_a : rot_b)) % 3] =
               $urandom_range(1) ? (1 << FRAC) : -(1 << FRAC);
         end else if (kind == 0 && s % 5 == 4) begin
            for (int c = 0; c < 3; c++)
               v[c] = comp_type'($urandom_range(4 << FRAC, 1 << FRAC));
         end
         send_beat(s, v[0], v[1], v[2], n == 9);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_slot   = '0;
      req_comp_x = '0;
      req_comp_y = '0;
      req_comp_z = '0;
      req_last   = 1'b0;
      rsp_ready  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, unused slot, touching and just-apart boxes,
      // extreme components and parallel axes.
      send_beat(SLOT_A_CTR, '0, '0, '0, 1'b1);
      send_beat(4'd12, 32'sh7fffffff, 32'sh80000000, 32'shffffffff, 1'b1);
      send_beat(4'd1, 1 << FRAC, 0, 0, 1'b0);
      send_beat(4'd2, 0, 1 << FRAC, 0, 1'b0);
      send_beat(4'd3, 0, 0, 1 << FRAC, 1'b0);
      send_beat(SLOT_A_HALF, 1 << FRAC, 1 << FRAC, 1 << FRAC, 1'b0);
      send_beat(4'd6, 1 << FRAC, 0, 0, 1'b0);
      send_beat(4'd7, 0, 1 << FRAC, 0, 1'b0);
      send_beat(4'd8, 0, 0, 1 << FRAC, 1'b0);
      send_beat(SLOT_B_HALF, -(1 << FRAC), 1 << FRAC, 1 << FRAC, 1'b0);
      send_beat(SLOT_B_CTR, 2 << FRAC, 0, 0, 1'b1);
      send_beat(SLOT_B_CTR, (2 << FRAC) + 1, 0, 0, 1'b1);
      send_beat(SLOT_A_CTR, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
      send_beat(SLOT_B_CTR, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
      send_beat(4'd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
      send_beat(4'd6, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
      send_beat(SLOT_A_HALF, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
      send_beat(SLOT_B_HALF, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
      send_beat(4'd15, '0, '0, '0, 1'b1);
      // Hold off until every verdict is back.
      drain();

      // Random box pairs through the idling phases.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 78 : 29) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 78 : 29) : 0;
         while (beats_sent < 19 + 500 * (phase + 1))
            send_box_pair();
         drain();
      end

      repeat (100) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog, well above a run in which every beat starts a full test.
   initial begin
      #400_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
